FILE: src/wfra_pkg.sv
`default_nettype none
package wfra_pkg;

  localparam int MAX_FLOWS_DEF = 16;
  localparam int RATE_BITS_DEF = 32;

  localparam int KIND_W   = 2;
  localparam int SLOT_W   = 4;
  localparam int RATE_W   = 32;
  localparam int WEIGHT_W = 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_REG   = 2'd0,
    KIND_UNREG = 2'd1,
    KIND_UPD   = 2'd2
  } kind_t;

endpackage
`default_nettype wire

FILE: src/wfra_if.sv
`default_nettype none
interface flow_req_if;
  logic                          valid;
  logic                          ready;
  logic [wfra_pkg::KIND_W-1:0]   kind;
  logic [wfra_pkg::SLOT_W-1:0]   slot;
  logic [wfra_pkg::RATE_W-1:0]   cc_rate;
  logic [wfra_pkg::RATE_W-1:0]   wanted_rate;
  logic [wfra_pkg::WEIGHT_W-1:0] weight;

  modport source (output valid, kind, slot, cc_rate, wanted_rate, weight, input ready);
  modport sink (input valid, kind, slot, cc_rate, wanted_rate, weight, output ready);
endinterface

interface flow_grant_if;
  logic                        valid;
  logic                        ready;
  logic [wfra_pkg::SLOT_W-1:0] out_slot;
  logic [wfra_pkg::RATE_W-1:0] granted_rate;
  logic                        last;

  modport source (output valid, out_slot, granted_rate, last, input ready);
  modport sink (input valid, out_slot, granted_rate, last, output ready);
endinterface
`default_nettype wire

FILE: src/wfra_ram.sv
`default_nettype none
module wfra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: src/weighted_flow_rate_allocator.sv
`default_nettype none
// Weighted flow rate allocator.
// Channel req (valid/ready) takes one item: register, unregister or rate
// update of a flow slot. Channel gnt (valid/ready) returns one item per
// active flow, in slot order, after an accepted update; last marks the end.
// Register and unregister give no results.
// req.ready is high only while the sequencer is idle, so one item is in
// work at a time. A register is applied in the idle state; an unregister
// reads its slot through a lookup and an apply state. An update does the
// same, then with more than one flow a clearing pass over every slot and up
// to MAX_FLOWS+1 sharing passes; each pass visits every slot and runs the
// bit-serial divider that all flows share for each flow still below its
// wanted rate. A pass that caps a flow returns to the check. The report then
// visits every slot and returns one item per active flow.
// Flow entries are in one single-port-write table RAM, read one slot a cycle.
// The result register holds its item while gnt.ready is low and the
// sequencer waits; nothing is dropped.
// Reset clears the active bits, the flow count, the rate sum and the result
// valid; table entries are only read once written.
module weighted_flow_rate_allocator #(
  parameter int MAX_FLOWS = wfra_pkg::MAX_FLOWS_DEF,
  parameter int RATE_BITS = wfra_pkg::RATE_BITS_DEF
) (
  input wire logic      clk,
  input wire logic      rst,
  flow_req_if.sink      req,
  flow_grant_if.source  gnt
);

  localparam int SW   = $clog2(MAX_FLOWS);
  localparam int SUMW = RATE_BITS + 8;
  localparam int PW   = SUMW + 8;
  localparam int WSW  = 8 + SW;
  localparam int CW   = $clog2(PW + 1);
  localparam int EW   = 8 + 2 * RATE_BITS;
  localparam int CNTW = $clog2(MAX_FLOWS + 1);
  localparam int PCW  = $clog2(MAX_FLOWS + 2);
  localparam int FW   = wfra_pkg::RATE_W;
  localparam int XW   = RATE_BITS + FW;
  localparam int SXW  = SW + wfra_pkg::SLOT_W;
  localparam logic [SUMW-1:0] SUM_MAX  = '1;
  localparam logic [SUMW-1:0] RATE_MAX = {8'd0, {RATE_BITS{1'b1}}};

  typedef enum logic [3:0] {
    S_IDLE, S_LOOK, S_APPLY, S_IRD, S_IUSE, S_CHECK, S_PRD, S_PUSE,
    S_DIV, S_DEC, S_PEND, S_ORD, S_OUSE, S_OWAIT
  } state_t;

  function automatic logic [SUMW-1:0] sum_adjust(input logic [SUMW-1:0] base,
                                                 input logic [RATE_BITS-1:0] plus,
                                                 input logic [RATE_BITS-1:0] minus);
    logic [SUMW:0]   t;
    logic [SUMW-1:0] c;
    t = {1'b0, base} + (SUMW + 1)'(plus);
    c = (t > {1'b0, SUM_MAX}) ? SUM_MAX : t[SUMW-1:0];
    if (c < SUMW'(minus)) begin
      return '0;
    end
    return c - SUMW'(minus);
  endfunction

  state_t                state;
  logic [MAX_FLOWS-1:0]  active;
  logic [SUMW-1:0]       rate_sum;
  logic [CNTW-1:0]       flow_count;
  wfra_pkg::kind_t       ikind;
  logic [SW-1:0]         islot;
  logic [RATE_BITS-1:0]  icc;
  logic [RATE_BITS-1:0]  iwant;
  logic [SW-1:0]         idx;
  logic [WSW-1:0]        wsum;
  logic [SUMW-1:0]       left;
  logic [SUMW-1:0]       agg;
  logic [PCW-1:0]        passes;
  logic                  capped;
  logic [PW-1:0]         dq;
  logic [WSW-1:0]        rem;
  logic [CW-1:0]         dcnt;
  logic                  out_valid;
  logic [wfra_pkg::SLOT_W-1:0] out_slot;
  logic [FW-1:0]         out_rate;
  logic                  out_last;

  // Input fields fitted to the internal widths
  logic [XW-1:0]         cc_x, want_x;
  logic [RATE_BITS-1:0]  cc_in, want_in;
  logic [SXW-1:0]        slot_x;
  logic [SW-1:0]         slot_i;
  logic                  slot_ok;
  wfra_pkg::kind_t       kind_in;

  assign cc_x    = {{RATE_BITS{1'b0}}, req.cc_rate};
  assign want_x  = {{RATE_BITS{1'b0}}, req.wanted_rate};
  assign cc_in   = cc_x[RATE_BITS-1:0];
  assign want_in = want_x[RATE_BITS-1:0];
  assign slot_x  = {{SW{1'b0}}, req.slot};
  assign slot_i  = slot_x[SW-1:0];
  assign slot_ok = slot_x < SXW'(MAX_FLOWS);
  assign kind_in = wfra_pkg::kind_t'(req.kind);

  // Table RAM: {weight, wanted, granted}
  logic                 we;
  logic [SW-1:0]        waddr, raddr;
  logic [EW-1:0]        wdata, rdata;
  logic [7:0]           rd_weight;
  logic [RATE_BITS-1:0] rd_wanted, rd_granted;

  assign rd_weight  = rdata[EW-1 -: 8];
  assign rd_wanted  = rdata[2*RATE_BITS-1 -: RATE_BITS];
  assign rd_granted = rdata[RATE_BITS-1:0];
  assign raddr      = (state == S_LOOK || state == S_APPLY) ? islot : idx;

  wfra_ram #(.WIDTH(EW), .DEPTH(MAX_FLOWS)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Shared arithmetic
  logic [SUMW-1:0]      sum_new, sum_sat;
  logic [PW-1:0]        prod;
  logic [WSW:0]         trial, diff;
  logic                 ge;
  logic [SUMW-1:0]      share;
  logic                 cap;
  logic                 idx_end;
  logic                 higher;
  logic [SXW-1:0]       idx_x;
  logic [XW-1:0]        rate_x;

  assign sum_new = sum_adjust(rate_sum, (ikind == wfra_pkg::KIND_UPD) ? icc : '0, rd_granted);
  assign sum_sat = (sum_new > RATE_MAX) ? RATE_MAX : sum_new;
  assign prod    = PW'(left) * PW'(rd_weight);
  assign trial   = {rem, dq[PW-1]};
  assign ge      = trial >= {1'b0, wsum};
  assign diff    = trial - {1'b0, wsum};
  assign share   = dq[SUMW-1:0];
  assign cap     = share >= SUMW'(rd_wanted);
  assign idx_end = idx == SW'(MAX_FLOWS - 1);
  assign idx_x   = {{wfra_pkg::SLOT_W{1'b0}}, idx};
  assign rate_x  = {{FW{1'b0}}, rd_granted};

  always_comb begin
    higher = 1'b0;
    for (int j = 0; j < MAX_FLOWS; j++) begin
      if (j > int'(idx) && active[j]) begin
        higher = 1'b1;
      end
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = {rd_weight, rd_wanted, rd_granted};
    case (state)
      S_IDLE: begin
        if (req.valid && kind_in == wfra_pkg::KIND_REG && slot_ok && !active[slot_i]) begin
          we    = 1'b1;
          waddr = slot_i;
          wdata = {req.weight, want_in, cc_in};
        end
      end
      S_APPLY: begin
        if (ikind == wfra_pkg::KIND_UPD) begin
          we    = 1'b1;
          waddr = islot;
          wdata = {rd_weight, iwant,
                   (flow_count > CNTW'(1)) ? rd_granted : sum_sat[RATE_BITS-1:0]};
        end
      end
      S_IUSE: begin
        if (active[idx]) begin
          we    = 1'b1;
          wdata = {rd_weight, rd_wanted, {RATE_BITS{1'b0}}};
        end
      end
      S_DEC: begin
        we    = 1'b1;
        wdata = {rd_weight, rd_wanted, cap ? rd_wanted : share[RATE_BITS-1:0]};
      end
      default: ;
    endcase
  end

  assign req.ready        = (state == S_IDLE);
  assign gnt.valid        = out_valid;
  assign gnt.out_slot     = out_slot;
  assign gnt.granted_rate = out_rate;
  assign gnt.last         = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      active     <= '0;
      rate_sum   <= '0;
      flow_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            ikind <= kind_in;
            islot <= slot_i;
            icc   <= cc_in;
            iwant <= want_in;
            if (slot_ok) begin
              if (kind_in == wfra_pkg::KIND_REG && !active[slot_i]) begin
                active[slot_i] <= 1'b1;
                rate_sum       <= sum_adjust(rate_sum, cc_in, '0);
                flow_count     <= flow_count + CNTW'(1);
              end else if ((kind_in == wfra_pkg::KIND_UNREG || kind_in == wfra_pkg::KIND_UPD)
                           && active[slot_i]) begin
                state <= S_LOOK;
              end
            end
          end
        end
        S_LOOK: state <= S_APPLY;
        S_APPLY: begin
          rate_sum <= sum_new;
          idx      <= '0;
          if (ikind == wfra_pkg::KIND_UNREG) begin
            active[islot] <= 1'b0;
            flow_count    <= flow_count - CNTW'(1);
            state         <= S_IDLE;
          end else if (flow_count > CNTW'(1)) begin
            wsum  <= '0;
            state <= S_IRD;
          end else begin
            state <= S_ORD;
          end
        end
        S_IRD: state <= S_IUSE;
        S_IUSE: begin
          if (active[idx]) begin
            wsum <= wsum + WSW'(rd_weight);
          end
          if (idx_end) begin
            left   <= rate_sum;
            agg    <= '0;
            passes <= '0;
            state  <= S_CHECK;
          end else begin
            idx   <= idx + SW'(1);
            state <= S_IRD;
          end
        end
        S_CHECK: begin
          idx <= '0;
          if ({1'b0, left} > ({1'b0, agg} + (SUMW + 1)'(1)) && wsum != '0
              && passes < PCW'(MAX_FLOWS + 1)) begin
            passes <= passes + PCW'(1);
            agg    <= '0;
            capped <= 1'b0;
            state  <= S_PRD;
          end else begin
            state <= S_ORD;
          end
        end
        S_PRD: state <= S_PUSE;
        S_PUSE: begin
          if (!active[idx] || rd_granted >= rd_wanted) begin
            if (idx_end) begin
              state <= S_PEND;
            end else begin
              idx   <= idx + SW'(1);
              state <= S_PRD;
            end
          end else if (wsum == '0) begin
            dq    <= '0;
            state <= S_DEC;
          end else begin
            dq    <= prod;
            rem   <= '0;
            dcnt  <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem  <= ge ? diff[WSW-1:0] : trial[WSW-1:0];
          dq   <= {dq[PW-2:0], ge};
          dcnt <= dcnt + CW'(1);
          if (dcnt == CW'(PW - 1)) begin
            state <= S_DEC;
          end
        end
        S_DEC: begin
          if (cap) begin
            left   <= left - SUMW'(rd_wanted);
            wsum   <= wsum - WSW'(rd_weight);
            capped <= 1'b1;
          end else begin
            agg <= agg + share;
          end
          if (idx_end) begin
            state <= S_PEND;
          end else begin
            idx   <= idx + SW'(1);
            state <= S_PRD;
          end
        end
        S_PEND: begin
          idx   <= '0;
          state <= capped ? S_CHECK : S_ORD;
        end
        S_ORD: begin
          if (active[idx]) begin
            state <= S_OUSE;
          end else if (idx_end) begin
            state <= S_IDLE;
          end else begin
            idx <= idx + SW'(1);
          end
        end
        S_OUSE: begin
          out_valid <= 1'b1;
          out_slot  <= idx_x[wfra_pkg::SLOT_W-1:0];
          out_rate  <= rate_x[FW-1:0];
          out_last  <= !higher;
          state     <= S_OWAIT;
        end
        S_OWAIT: begin
          if (gnt.ready) begin
            out_valid <= 1'b0;
            if (idx_end) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + SW'(1);
              state <= S_ORD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_valid_in_wait: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_OWAIT)
    else $error("result shown outside the report wait");

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    flow_count == CNTW'($countones(active)))
    else $error("flow count disagrees with active bits");

  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem < wsum)
    else $error("divider remainder out of range");

  a_pass_limit: assert property (@(posedge clk) disable iff (rst)
    state == S_PRD |-> passes <= PCW'(MAX_FLOWS + 1))
    else $error("too many sharing passes");
`endif

endmodule
`default_nettype wire
